/* design/ftn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftn_pkg
// Shared types and defaults for the flat triangle normal unit.
// ----------------------------------------------------------------------------
package ftn_pkg;

    localparam int FIELD_WIDTH          = 16;
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] vertex_a_x;
        logic signed [FIELD_WIDTH-1:0] vertex_a_y;
        logic signed [FIELD_WIDTH-1:0] vertex_a_z;
        logic signed [FIELD_WIDTH-1:0] vertex_b_x;
        logic signed [FIELD_WIDTH-1:0] vertex_b_y;
        logic signed [FIELD_WIDTH-1:0] vertex_b_z;
        logic signed [FIELD_WIDTH-1:0] vertex_c_x;
        logic signed [FIELD_WIDTH-1:0] vertex_c_y;
        logic signed [FIELD_WIDTH-1:0] vertex_c_z;
        logic                          last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] normal_x;
        logic signed [FIELD_WIDTH-1:0] normal_y;
        logic signed [FIELD_WIDTH-1:0] normal_z;
        logic                          degenerate;
        logic                          mesh_end;
    } tri_out_t;

endpackage
`default_nettype wire

/* design/flat_triangle_normal.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flat_triangle_normal
// Face normal of one triangle: cross product of the edges, floor integer
// square root of its squared length, and restoring division to Q1.FRAC.
// ----------------------------------------------------------------------------
// The square root pipeline (one root bit per stage) and the divider pipeline
// (one quotient bit per stage) set the pipeline depth.
// Throughput: one beat per cycle; the whole pipe holds when the output beat
// is not taken.
// Reset: synchronous active-low aresetn clears all valid bits.
module flat_triangle_normal
    import ftn_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tri_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tri_out_t      m_data
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int MW = PW;
    localparam int H  = MW / 2;
    localparam int HW = MW - H;
    localparam int RW = MW + 1;
    localparam int SW = 2 * RW;
    localparam int QW = F + 1;
    localparam int QX = (QW > 17) ? QW : 17;
    localparam logic [QX-1:0] POS_MAX = QX'(32767);
    localparam logic [QX-1:0] NEG_MAX = QX'(32768);

    typedef struct packed {
        logic       last;
        logic       deg;
        logic [2:0] neg;
    } side_t;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: edges
    logic signed [CW-1:0] cin[9];
    assign cin[0] = signed'(CW'(unsigned'(s_data.vertex_a_x)));
    assign cin[1] = signed'(CW'(unsigned'(s_data.vertex_a_y)));
    assign cin[2] = signed'(CW'(unsigned'(s_data.vertex_a_z)));
    assign cin[3] = signed'(CW'(unsigned'(s_data.vertex_b_x)));
    assign cin[4] = signed'(CW'(unsigned'(s_data.vertex_b_y)));
    assign cin[5] = signed'(CW'(unsigned'(s_data.vertex_b_z)));
    assign cin[6] = signed'(CW'(unsigned'(s_data.vertex_c_x)));
    assign cin[7] = signed'(CW'(unsigned'(s_data.vertex_c_y)));
    assign cin[8] = signed'(CW'(unsigned'(s_data.vertex_c_z)));

    logic                 v1_reg, l1_reg;
    logic signed [EW-1:0] e1_reg[3], e2_reg[3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EW'(cin[3+i]) - EW'(cin[i]);
                e2_reg[i] <= EW'(cin[6+i]) - EW'(cin[i]);
            end
            l1_reg <= s_data.last_triangle;
        end
    end

    // stage 2: cross product terms
    logic                 v2_reg, l2_reg;
    logic signed [PW-1:0] p_reg[6];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
            p_reg[1] <= PW'(e1_reg[2]) * PW'(e2_reg[1]);
            p_reg[2] <= PW'(e1_reg[2]) * PW'(e2_reg[0]);
            p_reg[3] <= PW'(e1_reg[0]) * PW'(e2_reg[2]);
            p_reg[4] <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
            p_reg[5] <= PW'(e1_reg[1]) * PW'(e2_reg[0]);
            l2_reg   <= l1_reg;
        end
    end

    // stage 3: cross product magnitude and sign
    logic                 v3_reg;
    side_t                sd3_reg;
    logic        [MW-1:0] m3_reg[3];
    logic signed [NW-1:0] n_next[3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i] = NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                m3_reg[i] <= n_next[i][NW-1] ? MW'(-n_next[i]) : MW'(n_next[i]);
                sd3_reg.neg[i] <= n_next[i][NW-1];
            end
            sd3_reg.deg  <= (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
            sd3_reg.last <= l2_reg;
        end
    end

    // stage 4: split squares
    logic              v4_reg;
    side_t             sd4_reg;
    logic [MW-1:0]     m4_reg[3];
    logic [2*HW-1:0]   hh_reg[3];
    logic [MW-1:0]     hl_reg[3];
    logic [2*H-1:0]    ll_reg[3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= (2*HW)'(m3_reg[i][MW-1:H]) * (2*HW)'(m3_reg[i][MW-1:H]);
                hl_reg[i] <= MW'(m3_reg[i][MW-1:H]) * MW'(m3_reg[i][H-1:0]);
                ll_reg[i] <= (2*H)'(m3_reg[i][H-1:0]) * (2*H)'(m3_reg[i][H-1:0]);
            end
            m4_reg  <= m3_reg;
            sd4_reg <= sd3_reg;
        end
    end

    // stage 5: per-component squares
    logic          v5_reg;
    side_t         sd5_reg;
    logic [MW-1:0] m5_reg[3];
    logic [SW-1:0] q5_reg[3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                q5_reg[i] <= (SW'(hh_reg[i]) << (2*H)) + (SW'(hl_reg[i]) << (H+1))
                           + SW'(ll_reg[i]);
            end
            m5_reg  <= m4_reg;
            sd5_reg <= sd4_reg;
        end
    end

    // stage 6: squared length
    logic          v6_reg;
    side_t         sd6_reg;
    logic [MW-1:0] m6_reg[3];
    logic [SW-1:0] sq6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq6_reg <= q5_reg[0] + q5_reg[1] + q5_reg[2];
            m6_reg  <= m5_reg;
            sd6_reg <= sd5_reg;
        end
    end

    // square root pipe, one root bit per stage
    logic          sv_reg[RW];
    side_t         ssd_reg[RW];
    logic [MW-1:0] sm_reg[RW][3];
    logic [SW-1:0] ssq_reg[RW];
    logic [RW-1:0] root_reg[RW];
    logic [RW+1:0] rem_reg[RW];

    logic [SW-1:0] sq_in[RW];
    logic [RW-1:0] root_in[RW];
    logic [RW+1:0] rem_in[RW];
    logic [RW+1:0] rsh[RW];
    logic [RW+1:0] trial[RW];
    logic [RW-1:0] root_next[RW];
    logic [RW+1:0] rem_next[RW];

    always_comb begin
        sq_in[0]   = sq6_reg;
        root_in[0] = '0;
        rem_in[0]  = '0;
        for (int k = 1; k < RW; k++) begin
            sq_in[k]   = ssq_reg[k-1];
            root_in[k] = root_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
        end
        for (int k = 0; k < RW; k++) begin
            rsh[k]   = {rem_in[k][RW-1:0], sq_in[k][2*(RW-1-k) +: 2]};
            trial[k] = (RW+2)'({root_in[k], 2'b01});
            if (rsh[k] >= trial[k]) begin
                rem_next[k]  = rsh[k] - trial[k];
                root_next[k] = {root_in[k][RW-2:0], 1'b1};
            end else begin
                rem_next[k]  = rsh[k];
                root_next[k] = {root_in[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sm_reg[0]  <= m6_reg;
            ssd_reg[0] <= sd6_reg;
            for (int k = 1; k < RW; k++) begin
                sm_reg[k]  <= sm_reg[k-1];
                ssd_reg[k] <= ssd_reg[k-1];
            end
            for (int k = 0; k < RW; k++) begin
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                ssq_reg[k]  <= sq_in[k];
            end
        end
    end

    // divider pipe, one quotient bit per stage, three lanes
    logic          dv_reg[QW];
    side_t         dsd_reg[QW];
    logic [RW-1:0] dlen_reg[QW];
    logic [RW:0]   drem_reg[QW][3];
    logic [QW-1:0] dq_reg[QW][3];

    logic [RW-1:0] len_in[QW];
    logic [RW:0]   r_try[QW][3];
    logic [QW-1:0] q_in[QW][3];

    always_comb begin
        len_in[0] = root_reg[RW-1];
        for (int i = 0; i < 3; i++) begin
            r_try[0][i] = (RW+1)'(sm_reg[RW-1][i]);
            q_in[0][i]  = '0;
        end
        for (int k = 1; k < QW; k++) begin
            len_in[k] = dlen_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                r_try[k][i] = {drem_reg[k-1][i][RW-1:0], 1'b0};
                q_in[k][i]  = dq_reg[k-1][i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dsd_reg[0] <= ssd_reg[RW-1];
            for (int k = 1; k < QW; k++) begin
                dsd_reg[k] <= dsd_reg[k-1];
            end
            for (int k = 0; k < QW; k++) begin
                dlen_reg[k] <= len_in[k];
                for (int i = 0; i < 3; i++) begin
                    if (r_try[k][i] >= (RW+1)'(len_in[k])) begin
                        drem_reg[k][i] <= r_try[k][i] - (RW+1)'(len_in[k]);
                        dq_reg[k][i]   <= {q_in[k][i][QW-2:0], 1'b1};
                    end else begin
                        drem_reg[k][i] <= r_try[k][i];
                        dq_reg[k][i]   <= {q_in[k][i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // output beat with saturation
    logic [QX-1:0]         qx[3];
    logic signed [15:0]    comp[3];
    side_t                 fsd;

    always_comb begin
        fsd = dsd_reg[QW-1];
        for (int i = 0; i < 3; i++) begin
            qx[i] = QX'(dq_reg[QW-1][i]);
            if (fsd.deg) begin
                comp[i] = '0;
            end else if (fsd.neg[i]) begin
                comp[i] = (qx[i] > NEG_MAX) ? 16'sh8000 : 16'(-qx[i]);
            end else begin
                comp[i] = (qx[i] > POS_MAX) ? 16'sh7fff : 16'(qx[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data.normal_x   <= comp[0];
            m_data.normal_y   <= comp[1];
            m_data.normal_z   <= comp[2];
            m_data.degenerate <= fsd.deg;
            m_data.mesh_end   <= fsd.last;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            for (int k = 0; k < RW; k++) sv_reg[k] <= 1'b0;
            for (int k = 0; k < QW; k++) dv_reg[k] <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            sv_reg[0] <= v6_reg;
            for (int k = 1; k < RW; k++) sv_reg[k] <= sv_reg[k-1];
            dv_reg[0] <= sv_reg[RW-1];
            for (int k = 1; k < QW; k++) dv_reg[k] <= dv_reg[k-1];
            m_valid <= dv_reg[QW-1];
        end
    end

endmodule
`default_nettype wire

/* tb/sv/flat_triangle_normal_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_triangle_normal_test
// Drives triangles into the face normal unit under random valid/ready gaps,
// predicts each normal with exact wide arithmetic and checks every beat.
// ----------------------------------------------------------------------------
module flat_triangle_normal_test;
    import ftn_pkg::*;

    localparam int CW   = COORD_WIDTH_DEF;
    localparam int FRAC = NORMAL_FRAC_BITS_DEF;
    localparam int LATENCY = 7 + (2*CW+3) + (FRAC+1);
    localparam int N_RANDOM = 1530;
    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tri_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tri_out_t m_data;

    flat_triangle_normal dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tri_out_t pending_normals[$];
    int       errors;
    int       beats_out;
    int       degen_seen;
    int       idle_cycles;
    bit       quiet_mode;
    bit       hold_sink;
    bit       stim_done;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic signed [63:0] coord_of(logic [15:0] f);
        logic [CW-1:0] low;
        low = f[CW-1:0];
        return 64'(signed'(low));
    endfunction

    function automatic logic [127:0] root_floor(logic [127:0] x);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rem = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((x >> (2*i)) & 128'd3);
            root = root << 1;
            trial = (root << 1) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 128'd1;
            end
        end
        return root;
    endfunction

    function automatic logic [15:0] scale_q(logic signed [63:0] c, logic [127:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = c < 0 ? 128'(-c) : 128'(c);
        q = (mag << FRAC) / len;
        if (c < 0) return q > 128'd32768 ? 16'h8000 : 16'(-q);
        return q > 128'd32767 ? 16'h7fff : 16'(q);
    endfunction

    function automatic tri_out_t face_normal(tri_in_t t);
        logic signed [63:0] ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [127:0] sq;
        logic [127:0] len;
        tri_out_t r;
        ax = coord_of(t.vertex_a_x);
        ay = coord_of(t.vertex_a_y);
        az = coord_of(t.vertex_a_z);
        e1x = coord_of(t.vertex_b_x) - ax;
        e1y = coord_of(t.vertex_b_y) - ay;
        e1z = coord_of(t.vertex_b_z) - az;
        e2x = coord_of(t.vertex_c_x) - ax;
        e2y = coord_of(t.vertex_c_y) - ay;
        e2z = coord_of(t.vertex_c_z) - az;
        nx = e1y*e2z - e1z*e2y;
        ny = e1z*e2x - e1x*e2z;
        nz = e1x*e2y - e1y*e2x;
        r = '0;
        r.mesh_end = t.last_triangle;
        if (nx == 0 && ny == 0 && nz == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        sq = 128'(nx)*128'(nx) + 128'(ny)*128'(ny) + 128'(nz)*128'(nz);
        len = root_floor(sq);
        r.normal_x = scale_q(nx, len);
        r.normal_y = scale_q(ny, len);
        r.normal_z = scale_q(nz, len);
        return r;
    endfunction

    function automatic tri_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, bit last);
        tri_in_t t;
        t.vertex_a_x = 16'(ax); t.vertex_a_y = 16'(ay); t.vertex_a_z = 16'(az);
        t.vertex_b_x = 16'(bx); t.vertex_b_y = 16'(by); t.vertex_b_z = 16'(bz);
        t.vertex_c_x = 16'(cx); t.vertex_c_y = 16'(cy); t.vertex_c_z = 16'(cz);
        t.last_triangle = last;
        return t;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 31)) - 16'd16;
            1: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                           : 16'h8000 + 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tri_in_t rand_tri();
        tri_in_t t;
        t.vertex_a_x = rand_coord(); t.vertex_a_y = rand_coord(); t.vertex_a_z = rand_coord();
        t.vertex_b_x = rand_coord(); t.vertex_b_y = rand_coord(); t.vertex_b_z = rand_coord();
        t.vertex_c_x = rand_coord(); t.vertex_c_y = rand_coord(); t.vertex_c_z = rand_coord();
        t.last_triangle = $urandom_range(0, 1);
        case ($urandom_range(0, 15))
            0: t.vertex_c_x = t.vertex_a_x;
            1: begin
                // collinear when 2b - a fits in 16 bits: c = a + 2(b - a)
                t.vertex_c_x = 16'(2*t.vertex_b_x - t.vertex_a_x);
                t.vertex_c_y = 16'(2*t.vertex_b_y - t.vertex_a_y);
                t.vertex_c_z = 16'(2*t.vertex_b_z - t.vertex_a_z);
            end
            2: begin
                t.vertex_b_x = t.vertex_a_x; t.vertex_b_y = t.vertex_a_y;
                t.vertex_b_z = t.vertex_a_z;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_beat(tri_in_t t, bit have_expect, tri_out_t want);
        while (!quiet_mode && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (have_expect && face_normal(t) !== want) begin
            errors++;
            $display("directed row disagrees with predictor: typed %h predicted %h",
                     want, face_normal(t));
        end
        pending_normals = {pending_normals, (have_expect ? want : face_normal(t))};
        @(negedge aclk);
    endtask

    typedef struct {
        tri_in_t  tri_in;
        bit       typed;
        tri_out_t want;
    } stim_row_t;

    stim_row_t directed[$];

    task automatic add_row(tri_in_t t, bit typed, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, bit d);
        stim_row_t r;
        r.tri_in = t;
        r.typed = typed;
        r.want = '{normal_x: x, normal_y: y, normal_z: z, degenerate: d,
                   mesh_end: t.last_triangle};
        directed = {directed, r};
    endtask

    initial begin
        tri_in_t t;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        errors = 0;
        quiet_mode = 1'b0;
        stim_done = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_row(make_tri(0,0,0, 0,0,0, 0,0,0, 0), 1, 0, 0, 0, 1);
        add_row(make_tri(0,0,0, 1,0,0, 0,1,0, 1), 1, 0, 0, 16384, 0);
        add_row(make_tri(0,0,0, 0,1,0, 1,0,0, 0), 1, 0, 0, 16'hc000, 0);
        add_row(make_tri(0,0,0, 0,1,0, 0,0,1, 0), 1, 16384, 0, 0, 0);
        add_row(make_tri(0,0,0, 0,0,1, 1,0,0, 1), 1, 0, 16384, 0, 0);
        // floor root lets n = (-1,-1,1) reach full scale on every axis
        add_row(make_tri(0,0,0, 1,0,1, 0,1,1, 0), 1, 16'hc000, 16'hc000, 16384, 0);
        add_row(make_tri(0,0,0, 0,-1,1, 1,0,0, 0), 1, 0, 16384, 16384, 0);
        add_row(make_tri(5,5,5, 5,5,5, 9,9,9, 1), 1, 0, 0, 0, 1);
        add_row(make_tri(0,0,0, 1,1,1, 2,2,2, 0), 1, 0, 0, 0, 1);
        add_row(make_tri(-32768,-32768,-32768, 32767,-32768,-32768,
                         -32768,32767,-32768, 1), 1, 0, 0, 16384, 0);
        add_row(make_tri(32767,32767,32767, -32768,32767,32767,
                         32767,-32768,32767, 0), 1, 0, 0, 16384, 0);
        add_row(make_tri(-32768,-32768,-32768, 32767,32767,32767,
                         32767,-32768,32767, 0), 0, 0, 0, 0, 0);
        add_row(make_tri(-32768,32767,-32768, 32767,-32768,32767,
                         -32768,-32768,32767, 1), 0, 0, 0, 0, 0);
        add_row(make_tri(100,-200,300, -400,500,-600, 700,800,-900, 0), 0, 0, 0, 0, 0);
        add_row(make_tri(-1,-1,-1, 0,0,0, 1,-1,0, 1), 0, 0, 0, 0, 0);
        add_row(make_tri(32767,0,-32768, -32768,32767,0, 0,-32768,32767, 0), 0, 0,0,0,0);

        foreach (directed[i]) send_beat(directed[i].tri_in, directed[i].typed,
                                        directed[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_mode = (n >= 300 && n < 550);
            if (n == 700) begin
                // sender holds until the pipe has drained
                s_valid <= 1'b0;
                while (pending_normals.size() != 0) @(negedge aclk);
            end
            t = rand_tri();
            send_beat(t, 0, '0);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        m_ready = 1'b0;
        hold_sink = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (beats_out == 900 && !hold_sink) begin
                hold_sink = 1'b1;
                m_ready <= 1'b0;
                repeat (3*LATENCY) @(negedge aclk);
            end
            m_ready <= quiet_mode ? 1'b1 : ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge aclk) begin
        tri_out_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out <= beats_out + 1;
            if (pending_normals.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", m_data);
            end else begin
                want = pending_normals.pop_front();
                if (want.degenerate) degen_seen++;
                if (m_data.normal_x !== want.normal_x || m_data.normal_y !== want.normal_y ||
                    m_data.normal_z !== want.normal_z ||
                    m_data.degenerate !== want.degenerate ||
                    m_data.mesh_end !== want.mesh_end) begin
                    errors++;
                    if (errors <= 10)
                        $display("normal mismatch: expected %0d %0d %0d d%0b e%0b got %0d %0d %0d d%0b e%0b",
                                 want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                                 want.mesh_end, m_data.normal_x, m_data.normal_y,
                                 m_data.normal_z, m_data.degenerate, m_data.mesh_end);
                end
            end
        end
    end

    initial begin
        beats_out = 0;
        degen_seen = 0;
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (stim_done && pending_normals.size() == 0) begin
                repeat (LATENCY + 10) @(posedge aclk);
                $display("covered %0d triangles, %0d degenerate, with drain and backpressure",
                         beats_out, degen_seen);
                if (errors == 0 && pending_normals.size() == 0)
                    $display("[ OK ] regression clean");
                else
                    $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
design/ftn_pkg.sv
design/flat_triangle_normal.sv
tb/sv/flat_triangle_normal_test.sv
